// ===== design/spq_pkg.sv =====
package spq_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned PRIO_W      = 32;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned MODE_W      = 2;
	localparam int unsigned COUNT_OUT_W = 5;

	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic signed [PRIO_W-1:0]  prio_t;
	typedef logic [STATUS_W-1:0]       status_t;
	typedef logic [MODE_W-1:0]         mode_t;
	typedef logic [COUNT_OUT_W-1:0]    count_out_t;

	// Result status codes.
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	// Operation codes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Ordering relation between a stored priority and the new one.
	localparam mode_t REL_LE = 2'd0;
	localparam mode_t REL_LT = 2'd1;
	localparam mode_t REL_GE = 2'd2;
	localparam mode_t REL_GT = 2'd3;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_ONE,
		IDX_INC,
		IDX_DEC,
		IDX_COUNT
	} idx_sel_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_ZERO
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_UP,
		WR_DOWN,
		WR_INSERT
	} wr_sel_t;

	typedef struct packed {
		logic     capture;
		logic     set_status;
		status_t  status;
		logic     take_pop;
		idx_sel_t idx_sel;
		logic     pos_zero;
		logic     pos_load;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic empty;
		logic full;
		logic scan_more;
		logic idx_eq_pos;
		logic idx_eq_count;
	} sts_t;

endpackage

// ===== design/spq_channels.sv =====
interface spq_item_if;
	logic          valid;
	logic          ready;
	logic          opcode;
	spq_pkg::data_t element_value;
	spq_pkg::prio_t priority_value;

	modport source (output valid, output opcode, output element_value,
		output priority_value, input ready);
	modport sink (input valid, input opcode, input element_value,
		input priority_value, output ready);
endinterface

interface spq_result_if;
	logic                valid;
	logic                ready;
	spq_pkg::data_t      popped_value;
	spq_pkg::prio_t      popped_priority;
	spq_pkg::status_t    status_code;
	logic                head_valid;
	spq_pkg::data_t      head_value;
	spq_pkg::prio_t      head_priority;
	spq_pkg::count_out_t entry_count;

	modport source (output valid, output popped_value, output popped_priority,
		output status_code, output head_valid, output head_value,
		output head_priority, output entry_count, input ready);
	modport sink (input valid, input popped_value, input popped_priority,
		input status_code, input head_valid, input head_value,
		input head_priority, input entry_count, output ready);
endinterface

interface spq_cfg_if;
	logic          valid;
	logic          ready;
	spq_pkg::mode_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/spq_ctrl.sv =====
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHR_RD,
		S_SHR_WR,
		S_INS,
		S_PSH_RD,
		S_PSH_WR,
		S_HEAD_RD,
		S_HEAD_CAP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.idx_sel = spq_pkg::IDX_HOLD;
		cmd.rd_sel  = spq_pkg::RD_IDX;
		cmd.wr_sel  = spq_pkg::WR_UP;
		cmd.status  = spq_pkg::STATUS_OK;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.is_pop) begin
					if (sts.full) begin
						cmd.set_status = 1'b1;
						cmd.status     = spq_pkg::STATUS_FULL;
						state_d        = S_HEAD_RD;
					end else if (sts.empty) begin
						cmd.pos_zero = 1'b1;
						cmd.idx_sel  = spq_pkg::IDX_ZERO;
						state_d      = S_INS;
					end else begin
						cmd.idx_sel = spq_pkg::IDX_ZERO;
						state_d     = S_SCAN_RD;
					end
				end else if (sts.empty) begin
					cmd.set_status = 1'b1;
					cmd.status     = spq_pkg::STATUS_EMPTY;
					state_d        = S_HEAD_RD;
				end else begin
					cmd.take_pop = 1'b1;
					cmd.idx_sel  = spq_pkg::IDX_ONE;
					state_d      = S_PSH_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = spq_pkg::RD_IDX;
				state_d    = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (sts.scan_more) begin
					cmd.idx_sel = spq_pkg::IDX_INC;
					state_d     = S_SCAN_RD;
				end else begin
					cmd.pos_load = 1'b1;
					cmd.idx_sel  = spq_pkg::IDX_COUNT;
					state_d      = S_SHR_RD;
				end
			end
			S_SHR_RD: begin
				if (sts.idx_eq_pos) begin
					state_d = S_INS;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = spq_pkg::RD_IDX_M1;
					state_d    = S_SHR_WR;
				end
			end
			S_SHR_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = spq_pkg::WR_UP;
				cmd.idx_sel = spq_pkg::IDX_DEC;
				state_d     = S_SHR_RD;
			end
			S_INS: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = spq_pkg::WR_INSERT;
				cmd.cnt_inc = 1'b1;
				state_d     = S_HEAD_RD;
			end
			S_PSH_RD: begin
				if (sts.idx_eq_count) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_HEAD_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = spq_pkg::RD_IDX;
					state_d    = S_PSH_WR;
				end
			end
			S_PSH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = spq_pkg::WR_DOWN;
				cmd.idx_sel = spq_pkg::IDX_INC;
				state_d     = S_PSH_RD;
			end
			S_HEAD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = spq_pkg::RD_ZERO;
				state_d    = S_HEAD_CAP;
			end
			S_HEAD_CAP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/spq_datapath.sv =====
module spq_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  spq_pkg::mode_t      cfg_data,
	input  logic                in_opcode,
	input  spq_pkg::data_t      in_value,
	input  spq_pkg::prio_t      in_priority,
	input  spq_pkg::cmd_t       cmd,
	output spq_pkg::sts_t       sts,
	output spq_pkg::data_t      popped_value,
	output spq_pkg::prio_t      popped_priority,
	output spq_pkg::status_t    status_code,
	output logic                head_valid,
	output spq_pkg::data_t      head_value,
	output spq_pkg::prio_t      head_priority,
	output spq_pkg::count_out_t entry_count
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned OW = spq_pkg::COUNT_OUT_W;

	spq_pkg::data_t mem_val [DEPTH];
	spq_pkg::prio_t mem_prio [DEPTH];

	spq_pkg::mode_t   mode_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    pos_q;
	logic             op_q;
	spq_pkg::data_t   elem_q;
	spq_pkg::prio_t   prio_q;
	spq_pkg::data_t   rd_val_q;
	spq_pkg::prio_t   rd_prio_q;
	spq_pkg::data_t   res_pv_q;
	spq_pkg::prio_t   res_pp_q;
	spq_pkg::status_t res_st_q;

	spq_pkg::data_t      popped_value_q;
	spq_pkg::prio_t      popped_priority_q;
	spq_pkg::status_t    status_code_q;
	logic                head_valid_q;
	spq_pkg::data_t      head_value_q;
	spq_pkg::prio_t      head_priority_q;
	spq_pkg::count_out_t entry_count_q;

	logic [CW-1:0]    idx_p1;
	logic [CW-1:0]    idx_m1;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	spq_pkg::data_t   wr_val;
	spq_pkg::prio_t   wr_prio;
	logic             rel;
	logic             count_nz;
	logic [CW+OW-1:0] count_ext;

	assign idx_p1    = idx_q + CW'(1);
	assign idx_m1    = idx_q - CW'(1);
	assign count_nz  = (count_q != '0);
	assign count_ext = {{OW{1'b0}}, count_q};

	// Stored priority from the scan read against the priority being pushed.
	always_comb begin
		case (mode_q)
			spq_pkg::REL_LE: rel = (rd_prio_q <= prio_q);
			spq_pkg::REL_LT: rel = (rd_prio_q < prio_q);
			spq_pkg::REL_GE: rel = (rd_prio_q >= prio_q);
			default:         rel = (rd_prio_q > prio_q);
		endcase
	end

	always_comb begin
		case (cmd.rd_sel)
			spq_pkg::RD_IDX:    rd_addr = idx_q[AW-1:0];
			spq_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
			default:            rd_addr = '0;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			spq_pkg::WR_UP: begin
				wr_addr = idx_q[AW-1:0];
				wr_val  = rd_val_q;
				wr_prio = rd_prio_q;
			end
			spq_pkg::WR_DOWN: begin
				wr_addr = idx_m1[AW-1:0];
				wr_val  = rd_val_q;
				wr_prio = rd_prio_q;
			end
			default: begin
				wr_addr = pos_q[AW-1:0];
				wr_val  = elem_q;
				wr_prio = prio_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_val[wr_addr]  <= wr_val;
			mem_prio[wr_addr] <= wr_prio;
		end
		if (cmd.rd_en) begin
			rd_val_q  <= mem_val[rd_addr];
			rd_prio_q <= mem_prio[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= spq_pkg::REL_LE;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_opcode;
			elem_q   <= in_value;
			prio_q   <= in_priority;
			res_pv_q <= '0;
			res_pp_q <= '0;
			res_st_q <= spq_pkg::STATUS_OK;
		end
		if (cmd.set_status) begin
			res_st_q <= cmd.status;
		end
		if (cmd.take_pop) begin
			res_pv_q <= head_value_q;
			res_pp_q <= head_priority_q;
		end
		case (cmd.idx_sel)
			spq_pkg::IDX_ZERO:  idx_q <= '0;
			spq_pkg::IDX_ONE:   idx_q <= CW'(1);
			spq_pkg::IDX_INC:   idx_q <= idx_p1;
			spq_pkg::IDX_DEC:   idx_q <= idx_m1;
			spq_pkg::IDX_COUNT: idx_q <= count_q;
			default:            idx_q <= idx_q;
		endcase
		if (cmd.pos_zero) begin
			pos_q <= '0;
		end else if (cmd.pos_load) begin
			pos_q <= rel ? idx_p1 : idx_q;
		end
		if (cmd.load_out) begin
			popped_value_q    <= res_pv_q;
			popped_priority_q <= res_pp_q;
			status_code_q     <= res_st_q;
			head_valid_q      <= count_nz;
			head_value_q      <= count_nz ? rd_val_q : '0;
			head_priority_q   <= count_nz ? rd_prio_q : '0;
			entry_count_q     <= count_ext[OW-1:0];
		end
	end

	always_comb begin
		sts.is_pop       = (op_q == spq_pkg::OP_POP);
		sts.empty        = !count_nz;
		sts.full         = (count_q == CW'(DEPTH));
		sts.scan_more    = rel && (idx_p1 < count_q);
		sts.idx_eq_pos   = (idx_q == pos_q);
		sts.idx_eq_count = (idx_q == count_q);
	end

	assign popped_value    = popped_value_q;
	assign popped_priority = popped_priority_q;
	assign status_code     = status_code_q;
	assign head_valid      = head_valid_q;
	assign head_value      = head_value_q;
	assign head_priority   = head_priority_q;
	assign entry_count     = entry_count_q;

endmodule

// ===== design/sorted_priority_queue_core.sv =====
// Sorted priority queue, one word at a time. Time from acceptance to result grows
// with the stored entries for a push or pop and includes any wait for the result
// register to be taken. A rejected word skips the walk over the single-ported
// entry memory, which reads each scanned entry and reads and writes each shifted
// entry. It can take the next word in the cycle after the result is loaded.
// Reset clears the entry count and sets the relation to less-or-equal.
module sorted_priority_queue_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	spq_item_if.sink     item,
	spq_result_if.source result,
	spq_cfg_if.sink      cfg
);

	// The controller sequences every operation; the datapath holds the entry
	// memory, the count, the walk index, the insert position and the result.
	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	// Relation writes are always taken; the user must send them only while idle.
	assign cfg.ready = 1'b1;

	// A push scans from the head for the insert position, then shifts the tail
	// up one entry at a time and writes the new word. A pop shifts the rest
	// down by one. Every operation ends by rereading the head entry so the
	// result reports the head after the step. The result register lets the
	// block accept the next word while a finished result still waits.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.in_opcode       (item.opcode),
		.in_value        (item.element_value),
		.in_priority     (item.priority_value),
		.cmd             (cmd),
		.sts             (sts),
		.popped_value    (result.popped_value),
		.popped_priority (result.popped_priority),
		.status_code     (result.status_code),
		.head_valid      (result.head_valid),
		.head_value      (result.head_value),
		.head_priority   (result.head_priority),
		.entry_count     (result.entry_count)
	);

	// An accepted word keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("input ready right after an accepted word");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result.valid || result.ready))
		else $error("result loaded over a pending result");

	// A pop on an empty queue reports an empty queue.
	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status_code == spq_pkg::STATUS_EMPTY)
		|-> !result.head_valid && (result.entry_count == '0))
		else $error("empty status with a valid head");

	// A dropped push means the queue is full, so a head exists.
	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status_code == spq_pkg::STATUS_FULL)
		|-> result.head_valid)
		else $error("full status without a valid head");

endmodule

// ===== sim/tb_sorted_priority_queue_core.sv =====
module tb_sorted_priority_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	// The slowest word is a push into 15 entries. Add the longest sender gap,
	// the longest receiver stall and the long hold-off, then take that several
	// times over.
	localparam int CYCLE_LIMIT = 400000;
	// A full push walk, with margin, for the quiet period after the last result.
	localparam int SETTLE_CYCLES = 64;

	// One result word as the block reports it.
	typedef struct packed {
		spq_pkg::data_t      popped_value;
		spq_pkg::prio_t      popped_priority;
		spq_pkg::status_t    status_code;
		logic                head_valid;
		spq_pkg::data_t      head_value;
		spq_pkg::prio_t      head_priority;
		spq_pkg::count_out_t entry_count;
	} outcome_t;

	// One row of the directed table. When known is set, want is the result
	// that the row must produce; otherwise the queue model decides.
	typedef struct packed {
		logic           op;
		spq_pkg::data_t elem;
		spq_pkg::prio_t prio;
		logic           known;
		outcome_t       want;
	} step_t;

	logic clk;
	logic arst_n;

	spq_item_if   item_ch();
	spq_result_if result_ch();
	spq_cfg_if    cfg_ch();

	sorted_priority_queue_core #(
		.DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// Shadow copy of the queue: entries from head (slot 0) to tail, the count
	// and the relation currently in force.
	spq_pkg::data_t shadow_values [QUEUE_DEPTH];
	spq_pkg::prio_t shadow_prios [QUEUE_DEPTH];
	int             shadow_count;
	spq_pkg::mode_t shadow_mode;

	// Results still owed by the block, oldest first.
	outcome_t awaited_results [$];

	// Side information that travels with the word currently offered.
	logic     word_known;
	outcome_t word_want;

	int  failures;
	int  cycle_count;
	int  sender_gap_odds;
	int  receiver_hold;
	bit  calm;

	outcome_t predicted;
	outcome_t observed;
	outcome_t oldest;

	step_t script [25];

	// True when a stored priority stands in the chosen relation to the new one,
	// so that a push walks on past it. Both sides are signed.
	function automatic bit walks_past(spq_pkg::prio_t held, spq_pkg::prio_t incoming);
		case (shadow_mode)
			spq_pkg::REL_LE: return held <= incoming;
			spq_pkg::REL_LT: return held < incoming;
			spq_pkg::REL_GE: return held >= incoming;
			default: return held > incoming;
		endcase
	endfunction

	// Applies one word to the shadow queue and returns the result it causes.
	function automatic outcome_t apply_queue_op(logic op, spq_pkg::data_t elem,
			spq_pkg::prio_t prio);
		outcome_t r;
		int       slot;
		int       i;
		r = '0;
		if (op == spq_pkg::OP_PUSH) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				r.status_code = spq_pkg::STATUS_FULL;
			end else begin
				slot = 0;
				while (slot < shadow_count && walks_past(shadow_prios[slot], prio))
					slot++;
				for (i = shadow_count; i > slot; i--) begin
					shadow_values[i] = shadow_values[i-1];
					shadow_prios[i] = shadow_prios[i-1];
				end
				shadow_values[slot] = elem;
				shadow_prios[slot] = prio;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status_code = spq_pkg::STATUS_EMPTY;
			end else begin
				r.popped_value = shadow_values[0];
				r.popped_priority = shadow_prios[0];
				for (i = 1; i < shadow_count; i++) begin
					shadow_values[i-1] = shadow_values[i];
					shadow_prios[i-1] = shadow_prios[i];
				end
				shadow_count--;
			end
		end
		r.status_code = (r.status_code == spq_pkg::STATUS_FULL ||
			r.status_code == spq_pkg::STATUS_EMPTY) ? r.status_code : spq_pkg::STATUS_OK;
		// An empty queue reports zeros in both head fields.
		if (shadow_count > 0) begin
			r.head_valid = 1'b1;
			r.head_value = shadow_values[0];
			r.head_priority = shadow_prios[0];
		end
		r.entry_count = spq_pkg::count_out_t'(shadow_count);
		return r;
	endfunction

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run is cut short if the block stops making progress.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** sorted_priority_queue_core: FAILED **");
		$finish;
	end

	// Result side ready. A long hold-off requested by the stimulus is counted
	// here, cycle by cycle; otherwise the receiver stalls in short random
	// bursts, and never once the calm final stretch has begun.
	initial begin : receiver
		int stall;
		stall = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold != 0) begin
				result_ch.ready = 1'b0;
				stall = receiver_hold - 1;
				receiver_hold = 0;
			end else if (stall != 0) begin
				stall--;
			end else if (!calm && arst_n && $urandom_range(0, 9) == 0) begin
				result_ch.ready = 1'b0;
				stall = $urandom_range(1, 13) - 1;
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	// Everything is sampled on the rising edge. A register write and an accepted
	// input word update the shadow state; an accepted result word is checked
	// against the oldest expectation. A result can never come out on the edge
	// that took its own word, so the order of these steps is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				shadow_mode = cfg_ch.data;
			if (item_ch.valid && item_ch.ready) begin
				predicted = apply_queue_op(item_ch.opcode, item_ch.element_value,
					item_ch.priority_value);
				awaited_results.push_back(word_known ? word_want : predicted);
			end
			if (result_ch.valid && result_ch.ready) begin
				observed = '{result_ch.popped_value, result_ch.popped_priority,
					result_ch.status_code, result_ch.head_valid, result_ch.head_value,
					result_ch.head_priority, result_ch.entry_count};
				if (awaited_results.size() == 0) begin
					failures++;
					$display("%0t ns: result word with none expected: pv=%0d pp=%0d st=%0d",
						$time, observed.popped_value, observed.popped_priority,
						observed.status_code);
				end else begin
					oldest = awaited_results.pop_front();
					if (observed.popped_value !== oldest.popped_value ||
							observed.popped_priority !== oldest.popped_priority ||
							observed.status_code !== oldest.status_code ||
							observed.head_valid !== oldest.head_valid ||
							observed.head_value !== oldest.head_value ||
							observed.head_priority !== oldest.head_priority ||
							observed.entry_count !== oldest.entry_count) begin
						failures++;
						$display("%0t ns: mismatch, expected pv=%0d pp=%0d st=%0d hv=%0b hd=%0d hp=%0d n=%0d",
							$time, oldest.popped_value, oldest.popped_priority,
							oldest.status_code, oldest.head_valid, oldest.head_value,
							oldest.head_priority, oldest.entry_count);
						$display("%0t ns:   actual   pv=%0d pp=%0d st=%0d hv=%0b hd=%0d hp=%0d n=%0d",
							$time, observed.popped_value, observed.popped_priority,
							observed.status_code, observed.head_valid, observed.head_value,
							observed.head_priority, observed.entry_count);
					end
				end
			end
		end
	end

	// Offers one word, after an optional random gap, and returns on the
	// falling edge after it was taken. Valid stays high so that the next
	// word can follow without a bubble.
	task automatic send_word(logic op, spq_pkg::data_t elem, spq_pkg::prio_t prio,
			logic known, outcome_t want);
		if (!calm && sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
			item_ch.valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.opcode = op;
		item_ch.element_value = elem;
		item_ch.priority_value = prio;
		word_known = known;
		word_want = want;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering words and waits until every owed result has been taken.
	task automatic drain_results();
		item_ch.valid = 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
	endtask

	// Writes the relation register. Only done with the block idle, so the
	// change lands between two words and the stored order is left as it is.
	task automatic set_relation(spq_pkg::mode_t m);
		drain_results();
		cfg_ch.valid = 1'b1;
		cfg_ch.data = m;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Random traffic in runs of 24 words. Each run leans toward filling the
	// queue, toward draining it, or mixes both, so the full and empty cases
	// come up often. Priorities often fall in a narrow band to force ties,
	// with full-range values and values at or near the extremes mixed in.
	task automatic random_phase(int words, int gap_odds);
		int             n;
		int             pop_pct;
		logic           op;
		spq_pkg::data_t elem;
		spq_pkg::prio_t prio;
		pop_pct = 50;
		sender_gap_odds = gap_odds;
		for (n = 0; n < words; n++) begin
			if (n % 24 == 0) begin
				case ($urandom_range(0, 2))
					0: pop_pct = 15;
					1: pop_pct = 85;
					default: pop_pct = 50;
				endcase
			end
			op = ($urandom_range(0, 99) < pop_pct) ? spq_pkg::OP_POP : spq_pkg::OP_PUSH;
			elem = ($urandom_range(0, 15) == 0) ?
				($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000) :
				spq_pkg::data_t'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: prio = spq_pkg::prio_t'($urandom_range(0, 6)) - 3;
				4, 5, 6: prio = spq_pkg::prio_t'($urandom);
				7: prio = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				default: prio = $urandom_range(0, 1) ?
					32'sh7FFF_FFFF - spq_pkg::prio_t'($urandom_range(0, 2)) :
					32'sh8000_0000 + spq_pkg::prio_t'($urandom_range(0, 2));
			endcase
			send_word(op, elem, prio, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int k;
		failures = 0;
		calm = 1'b0;
		receiver_hold = 0;
		sender_gap_odds = 4;
		shadow_count = 0;
		shadow_mode = spq_pkg::REL_LE;
		for (k = 0; k < QUEUE_DEPTH; k++) begin
			shadow_values[k] = '0;
			shadow_prios[k] = '0;
		end
		word_known = 1'b0;
		word_want = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = spq_pkg::OP_PUSH;
		item_ch.element_value = '0;
		item_ch.priority_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = spq_pkg::REL_LE;

		// Directed words, run with the relation at its reset value of
		// less-or-equal. The queue is filled past its depth and partly drained.
		script = '{
			// Pop of an empty queue: empty status, every value field zero.
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b1,
				'{32'sh0, 32'sh0, spq_pkg::STATUS_EMPTY, 1'b0, 32'sh0, 32'sh0, 5'd0}},
			// Largest element and priority into the empty queue.
			'{spq_pkg::OP_PUSH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1,
				'{32'sh0, 32'sh0, spq_pkg::STATUS_OK, 1'b1, 32'sh7FFF_FFFF,
					32'sh7FFF_FFFF, 5'd1}},
			// Smallest priority goes ahead of the largest.
			'{spq_pkg::OP_PUSH, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
				'{32'sh0, 32'sh0, spq_pkg::STATUS_OK, 1'b1, 32'sh8000_0000,
					32'sh8000_0000, 5'd2}},
			// Two equal priorities, which must leave in arrival order.
			'{spq_pkg::OP_PUSH, 32'sh0, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'shFFFF_FFFF, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b0, '0},
			// Fill up to the depth with varied patterns and some ties.
			'{spq_pkg::OP_PUSH, 32'sh5555_5555, 32'sh5, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'shAAAA_AAAA, -32'sh5, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh0F0F_0F0F, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'shF0F0_F0F0, 32'sh7FFF_FFFF, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh0000_0001, 32'sh8000_0000, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh8000_0001, 32'sh64, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh7FFF_FFFE, -32'sh64, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh1234_5678, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'shFEDC_BA98, 32'sh3, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh0000_FFFF, 32'sh3, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'shFFFF_0000, 32'sh1, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'sh00FF_00FF, -32'sh1, 1'b0, '0},
			'{spq_pkg::OP_PUSH, 32'shFF00_FF00, 32'sh2, 1'b0, '0},
			// Push into the full queue: dropped with a full status.
			'{spq_pkg::OP_PUSH, 32'sh7777_7777, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b0, '0},
			'{spq_pkg::OP_POP, 32'sh0, 32'sh0, 1'b0, '0}
		};

		// Reset is held low and then released on a falling edge.
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < $size(script); k++)
			send_word(script[k].op, script[k].elem, script[k].prio, script[k].known,
				script[k].want);

		// Every relation in turn, each change landing on whatever the queue
		// still holds from the phase before.
		set_relation(spq_pkg::REL_GE);
		random_phase(210, 8);

		// The receiver holds off for a long stretch while words keep coming,
		// so the block backs up and stops taking words.
		set_relation(spq_pkg::REL_LT);
		receiver_hold = 240;
		random_phase(210, 8);

		// The sender pauses until every owed result has been taken, then
		// resumes with no gaps of its own.
		drain_results();
		random_phase(210, 0);

		set_relation(spq_pkg::REL_GT);
		random_phase(210, 8);
		set_relation(spq_pkg::REL_LE);
		random_phase(210, 5);
		set_relation(spq_pkg::mode_t'($urandom_range(0, 3)));
		random_phase(210, 8);
		set_relation(spq_pkg::REL_GT);
		random_phase(100, 8);

		// Final stretch at full rate on both sides.
		calm = 1'b1;
		set_relation(spq_pkg::REL_LE);
		random_phase(170, 0);

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("** sorted_priority_queue_core: PASSED **");
		end else begin
			$display("** sorted_priority_queue_core: FAILED **");
		end
		$finish;
	end

endmodule
